### rtl/core/ptrt_pkg.sv
// ----------------------------------------------------------------------------
// ptrt_pkg
// shared types and codes of the periodic task release table
// ----------------------------------------------------------------------------
package ptrt_pkg;

    localparam int MAX_TASKS = 8;
    localparam int IDX_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W     = $clog2(MAX_TASKS + 1);

    localparam logic [1:0] REQ_CREATE   = 2'd0;
    localparam logic [1:0] REQ_TICK     = 2'd1;
    localparam logic [1:0] REQ_DISPATCH = 2'd2;

    localparam logic [1:0] MODE_READY     = 2'd0;
    localparam logic [1:0] MODE_BLOCKED   = 2'd1;
    localparam logic [1:0] MODE_SUSPENDED = 2'd2;
    localparam logic [1:0] MODE_INVALID   = 2'd3;

    localparam logic [1:0] STAT_OK         = 2'd0;
    localparam logic [1:0] STAT_NULL       = 2'd1;
    localparam logic [1:0] STAT_FULL       = 2'd2;
    localparam logic [1:0] STAT_PERIOD_BIG = 2'd3;

    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_TASK   = 1'b1;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] task_handle;
        logic [7:0]  period;
        logic [1:0]  initial_mode;
        logic [7:0]  init_delay;
    } req_t;

    typedef struct packed {
        logic        kind;
        logic [1:0]  status;
        logic [2:0]  slot;
        logic [15:0] run_handle;
        logic        last;
    } rsp_t;

    typedef struct packed {
        logic [15:0] handle;
        logic [7:0]  period;
        logic [1:0]  mode;
        logic [7:0]  ticks;
        logic [7:0]  delay;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_WALK  = 3'b010,
        ST_FLUSH = 3'b100
    } state_t;

endpackage

### rtl/core/periodic_task_release_table_top.sv
// ----------------------------------------------------------------------------
// periodic_task_release_table_top
// periodic task table held in one synchronous memory, walked slot by slot
// create: result strobed in the cycle after the transfer, busy stays low
// tick/dispatch: busy while the walk visits each task slot in turn, then in a flush
// state when a task was dispatched; one memory read and write per slot
// results strobe for one cycle each, the receiver cannot stall
// reset clears task count and control state; max_period returns to 255
// ----------------------------------------------------------------------------
module periodic_task_release_table_top
    import ptrt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  req_t       req,
    output logic       res_valid,
    output rsp_t       res,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data
);

    entry_t     table_mem [MAX_TASKS];
    entry_t     rd_data_reg;

    state_t     state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] proc_reg, proc_next;
    logic       disp_reg, disp_next;
    logic [7:0] max_period_reg;
    logic       held_valid_reg, held_valid_next;
    logic [IDX_W-1:0] held_idx_reg, held_idx_next;
    logic [15:0] held_handle_reg, held_handle_next;
    logic       res_valid_reg, res_valid_next;
    rsp_t       res_reg, res_next;

    logic       rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic       wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t     wr_data;
    entry_t     ent;
    logic [1:0] cr_status;
    logic       at_end;
    logic       emit;

    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;
    assign at_end    = ((CNT_W'(proc_reg) + CNT_W'(1)) == count_reg);

    // table memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            table_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= table_mem[rd_addr];
        end
    end

    always_comb
    begin
        if (req.task_handle == 16'd0)
        begin
            cr_status = STAT_NULL;
        end
        else if (count_reg >= CNT_W'(MAX_TASKS))
        begin
            cr_status = STAT_FULL;
        end
        else if (req.period > max_period_reg)
        begin
            cr_status = STAT_PERIOD_BIG;
        end
        else
        begin
            cr_status = STAT_OK;
        end
    end

    // slot update during the walk
    always_comb
    begin
        ent  = rd_data_reg;
        emit = 1'b0;
        if (disp_reg)
        begin
            if (rd_data_reg.mode == MODE_READY)
            begin
                if (rd_data_reg.delay != 8'd0)
                begin
                    ent.delay = rd_data_reg.delay - 8'd1;
                end
                else
                begin
                    emit     = 1'b1;
                    ent.mode = MODE_BLOCKED;
                end
            end
        end
        else if (rd_data_reg.mode == MODE_BLOCKED)
        begin
            if (rd_data_reg.ticks >= rd_data_reg.period)
            begin
                ent.mode  = MODE_READY;
                ent.ticks = 8'd1;
            end
            else
            begin
                ent.ticks = rd_data_reg.ticks + 8'd1;
            end
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        proc_next        = proc_reg;
        disp_next        = disp_reg;
        held_valid_next  = held_valid_reg;
        held_idx_next    = held_idx_reg;
        held_handle_next = held_handle_reg;
        res_valid_next   = 1'b0;
        res_next         = res_reg;
        rd_en            = 1'b0;
        rd_addr          = '0;
        wr_en            = 1'b0;
        wr_addr          = '0;
        wr_data          = ent;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (req.req_type)
                        REQ_CREATE:
                        begin
                            res_valid_next      = 1'b1;
                            res_next.kind       = KIND_STATUS;
                            res_next.status     = cr_status;
                            res_next.slot       = '0;
                            res_next.run_handle = '0;
                            res_next.last       = 1'b1;
                            if (cr_status == STAT_OK)
                            begin
                                res_next.slot       = 3'(count_reg);
                                wr_en               = 1'b1;
                                wr_addr             = count_reg[IDX_W-1:0];
                                wr_data.handle      = req.task_handle;
                                wr_data.period      = req.period;
                                wr_data.mode        = (req.initial_mode == MODE_INVALID)
                                                      ? MODE_SUSPENDED : req.initial_mode;
                                wr_data.ticks       = 8'd1;
                                wr_data.delay       = req.init_delay;
                                count_next          = count_reg + CNT_W'(1);
                            end
                        end
                        REQ_TICK, REQ_DISPATCH:
                        begin
                            if (count_reg != '0)
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = '0;
                                proc_next  = '0;
                                disp_next  = (req.req_type == REQ_DISPATCH);
                                state_next = ST_WALK;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_WALK:
            begin
                wr_en   = 1'b1;
                wr_addr = proc_reg;
                if (emit)
                begin
                    if (held_valid_reg)
                    begin
                        res_valid_next      = 1'b1;
                        res_next.kind       = KIND_TASK;
                        res_next.status     = STAT_OK;
                        res_next.slot       = 3'(held_idx_reg);
                        res_next.run_handle = held_handle_reg;
                        res_next.last       = 1'b0;
                    end
                    held_valid_next  = 1'b1;
                    held_idx_next    = proc_reg;
                    held_handle_next = rd_data_reg.handle;
                end
                if (at_end)
                begin
                    state_next = (held_valid_reg || emit) ? ST_FLUSH : ST_IDLE;
                end
                else
                begin
                    rd_en     = 1'b1;
                    rd_addr   = proc_reg + IDX_W'(1);
                    proc_next = proc_reg + IDX_W'(1);
                end
            end
            ST_FLUSH:
            begin
                res_valid_next      = 1'b1;
                res_next.kind       = KIND_TASK;
                res_next.status     = STAT_OK;
                res_next.slot       = 3'(held_idx_reg);
                res_next.run_handle = held_handle_reg;
                res_next.last       = 1'b1;
                held_valid_next     = 1'b0;
                state_next          = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            proc_reg       <= '0;
            disp_reg       <= 1'b0;
            max_period_reg <= 8'd255;
            held_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            proc_reg       <= proc_next;
            disp_reg       <= disp_next;
            held_valid_reg <= held_valid_next;
            res_valid_reg  <= res_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                max_period_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        held_idx_reg    <= held_idx_next;
        held_handle_reg <= held_handle_next;
        res_reg         <= res_next;
    end

endmodule

### rtl/core/ptrt_checker.sv
// ----------------------------------------------------------------------------
// ptrt_checker
// port-level checks of the periodic task release table
// ----------------------------------------------------------------------------
module ptrt_checker
    import ptrt_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input req_t       req,
    input logic       res_valid,
    input rsp_t       res,
    input logic       cfg_valid,
    input logic       cfg_ready,
    input logic [7:0] cfg_data
);

    // create transfer answers with one status result next cycle
    a_create_answer: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && req.req_type == REQ_CREATE
        |=> res_valid && res.kind == KIND_STATUS && res.last)
        else $error("create transfer without status result");

    // tick transfer produces no result
    a_tick_silent: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && req.req_type == REQ_TICK |=> !res_valid)
        else $error("tick transfer produced a result");

    // a failed create reports slot zero
    a_fail_slot: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.kind == KIND_STATUS && res.status != STAT_OK
        |-> res.slot == 3'd0 && res.run_handle == 16'd0)
        else $error("failed create with nonzero slot or handle");

    // the block is still busy while a non-final dispatch result is shown
    a_more_follow: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.kind == KIND_TASK && !res.last |-> busy)
        else $error("dispatch result not final but block idle");

    // config writes only while idle, with known data
    a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |-> !busy && !$isunknown(cfg_data))
        else $error("config transfer while busy or with unknown data");

endmodule

bind periodic_task_release_table_top ptrt_checker u_ptrt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .res_valid (res_valid),
    .res       (res),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
);

### dv/tb_periodic_task_release_table_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_periodic_task_release_table_top
// self-checking bench for the periodic task release table: a short directed
// script fills the table through every create status, then random tick,
// dispatch and create traffic runs in phases with different sender gaps and
// max_period settings; every strobed result is checked against an in-bench
// model of the table
// ----------------------------------------------------------------------------
module tb_periodic_task_release_table_top;
    import ptrt_pkg::*;

    localparam int          N_DIRECTED    = 25;
    localparam int          N_PHASES      = 4;
    localparam int          PHASE_ITEMS   = 120;
    localparam int          SETTLE_CYCLES = 16;
    localparam int unsigned CYCLE_LIMIT   = 200000;
    localparam logic [1:0]  REQ_UNUSED    = 2'd3;

    typedef enum logic { STEP_REQ, STEP_CFG } step_kind_t;

    typedef struct {
        step_kind_t kind;
        logic [7:0] cfg_value;
        req_t       item;
        bit         typed;
        rsp_t       want;
    } script_row_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       start;
    logic       busy;
    req_t       req;
    logic       res_valid;
    rsp_t       res;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [7:0] cfg_data;

    // table model
    logic [15:0] tbl_handle [MAX_TASKS];
    logic [7:0]  tbl_period [MAX_TASKS];
    logic [1:0]  tbl_mode   [MAX_TASKS];
    logic [7:0]  tbl_ticks  [MAX_TASKS];
    logic [7:0]  tbl_delay  [MAX_TASKS];
    int          n_tasks;
    logic [7:0]  period_limit;

    rsp_t        pending_results [$];
    script_row_t script [N_DIRECTED];
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;

    periodic_task_release_table_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .res_valid (res_valid),
        .res       (res),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic req_t mk_req(input logic [1:0] t, input logic [15:0] h,
                                    input logic [7:0] p, input logic [1:0] m,
                                    input logic [7:0] d);
        req_t r;
        r.req_type     = t;
        r.task_handle  = h;
        r.period       = p;
        r.initial_mode = m;
        r.init_delay   = d;
        return r;
    endfunction

    function automatic rsp_t mk_status(input logic [1:0] s, input logic [2:0] sl);
        rsp_t o;
        o            = '0;
        o.kind       = KIND_STATUS;
        o.status     = s;
        o.slot       = sl;
        o.last       = 1'b1;
        return o;
    endfunction

    function automatic req_t random_request();
        req_t        r;
        int unsigned sel;
        r.task_handle  = 16'($urandom);
        r.period       = 8'($urandom);
        r.initial_mode = 2'($urandom);
        r.init_delay   = 8'($urandom);
        sel            = $urandom_range(99);
        if (sel < 40)
        begin
            r.req_type = REQ_TICK;
        end
        else if (sel < 80)
        begin
            r.req_type = REQ_DISPATCH;
        end
        else if (sel < 95)
        begin
            r.req_type = REQ_CREATE;
            if ($urandom_range(7) == 0)
            begin
                r.task_handle = '0;
            end
        end
        else
        begin
            r.req_type = REQ_UNUSED;
        end
        return r;
    endfunction

    task automatic apply_request(input req_t r);
        rsp_t o;
        rsp_t held;
        bit   have_held;
        int   i;
        have_held = 1'b0;
        case (r.req_type)
            REQ_CREATE:
            begin
                o = mk_status(STAT_OK, 3'd0);
                if (r.task_handle == 16'd0)
                begin
                    o.status = STAT_NULL;
                end
                else if (n_tasks >= MAX_TASKS)
                begin
                    o.status = STAT_FULL;
                end
                else if (r.period > period_limit)
                begin
                    o.status = STAT_PERIOD_BIG;
                end
                else
                begin
                    tbl_handle[n_tasks] = r.task_handle;
                    tbl_period[n_tasks] = r.period;
                    tbl_mode[n_tasks]   = (r.initial_mode == MODE_INVALID) ?
                                          MODE_SUSPENDED : r.initial_mode;
                    tbl_ticks[n_tasks]  = 8'd1;
                    tbl_delay[n_tasks]  = r.init_delay;
                    o.slot              = 3'(n_tasks);
                    n_tasks++;
                end
                pending_results.push_back(o);
            end
            REQ_TICK:
            begin
                for (i = 0; i < n_tasks; i++)
                begin
                    if (tbl_mode[i] == MODE_BLOCKED)
                    begin
                        if (tbl_ticks[i] >= tbl_period[i])
                        begin
                            tbl_mode[i]  = MODE_READY;
                            tbl_ticks[i] = 8'd1;
                        end
                        else
                        begin
                            tbl_ticks[i] = tbl_ticks[i] + 8'd1;
                        end
                    end
                end
            end
            REQ_DISPATCH:
            begin
                for (i = 0; i < n_tasks; i++)
                begin
                    if (tbl_mode[i] == MODE_READY)
                    begin
                        if (tbl_delay[i] != 8'd0)
                        begin
                            tbl_delay[i] = tbl_delay[i] - 8'd1;
                        end
                        else
                        begin
                            if (have_held)
                            begin
                                pending_results.push_back(held);
                            end
                            held            = '0;
                            held.kind       = KIND_TASK;
                            held.status     = STAT_OK;
                            held.slot       = 3'(i);
                            held.run_handle = tbl_handle[i];
                            have_held       = 1'b1;
                            tbl_mode[i]     = MODE_BLOCKED;
                        end
                    end
                end
                if (have_held)
                begin
                    held.last = 1'b1;
                    pending_results.push_back(held);
                end
            end
            default:
            begin
            end
        endcase
    endtask

    // start stays high across back-to-back transfers
    task automatic issue(input req_t r);
        start <= 1'b1;
        req   <= r;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        apply_request(r);
    endtask

    task automatic pause(input int pct);
        if (pct > 0 && $urandom_range(99) < pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic set_max_period(input logic [7:0] v);
        start <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid    <= 1'b0;
        period_limit  = v;
    endtask

    // result checking
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && res_valid)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: kind %0d slot %0d handle %h",
                       res.kind, res.slot, res.run_handle);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (res.kind !== want.kind)
                begin
                    $error("kind: expected %0d, got %0d", want.kind, res.kind);
                    mismatch_count++;
                end
                if (res.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, res.status);
                    mismatch_count++;
                end
                if (res.slot !== want.slot)
                begin
                    $error("slot: expected %0d, got %0d", want.slot, res.slot);
                    mismatch_count++;
                end
                if (res.run_handle !== want.run_handle)
                begin
                    $error("run_handle: expected %h, got %h", want.run_handle,
                           res.run_handle);
                    mismatch_count++;
                end
                if (res.last !== want.last)
                begin
                    $error("last: expected %0d, got %0d", want.last, res.last);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        int          k;
        int          ph;
        int          counted;
        req_t        r;
        logic [7:0]  phase_limit [N_PHASES];
        int          phase_idle  [N_PHASES];

        rst_n        = 1'b0;
        start        = 1'b0;
        req          = '0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        n_tasks      = 0;
        period_limit = 8'd255;

        script[0]  = '{STEP_REQ, 8'd0, mk_req(REQ_DISPATCH, 16'h0000, 8'd0, MODE_READY, 8'd0),
                       1'b0, '0};
        script[1]  = '{STEP_REQ, 8'd0, mk_req(REQ_TICK, 16'h0000, 8'd0, MODE_READY, 8'd0),
                       1'b0, '0};
        script[2]  = '{STEP_REQ, 8'd0,
                       mk_req(REQ_CREATE, 16'h0000, 8'd200, MODE_BLOCKED, 8'd0),
                       1'b1, mk_status(STAT_NULL, 3'd0)};
        script[3]  = '{STEP_REQ, 8'd0, mk_req(REQ_CREATE, 16'h0001, 8'd0, MODE_READY, 8'd0),
                       1'b1, mk_status(STAT_OK, 3'd0)};
        script[4]  = '{STEP_CFG, 8'd1, '0, 1'b0, '0};
        script[5]  = '{STEP_REQ, 8'd0, mk_req(REQ_CREATE, 16'h1234, 8'd2, MODE_READY, 8'd0),
                       1'b1, mk_status(STAT_PERIOD_BIG, 3'd0)};
        script[6]  = '{STEP_REQ, 8'd0,
                       mk_req(REQ_CREATE, 16'h00AA, 8'd1, MODE_BLOCKED, 8'd1),
                       1'b1, mk_status(STAT_OK, 3'd1)};
        script[7]  = '{STEP_CFG, 8'd255, '0, 1'b0, '0};
        script[8]  = '{STEP_REQ, 8'd0,
                       mk_req(REQ_CREATE, 16'hFFFF, 8'd255, MODE_BLOCKED, 8'd255),
                       1'b1, mk_status(STAT_OK, 3'd2)};
        script[9]  = '{STEP_REQ, 8'd0,
                       mk_req(REQ_CREATE, 16'h1234, 8'd2, MODE_INVALID, 8'd0),
                       1'b1, mk_status(STAT_OK, 3'd3)};
        script[10] = '{STEP_REQ, 8'd0, mk_req(REQ_CREATE, 16'h5555, 8'd3, MODE_READY, 8'd2),
                       1'b1, mk_status(STAT_OK, 3'd4)};
        script[11] = '{STEP_REQ, 8'd0, mk_req(REQ_DISPATCH, 16'h0000, 8'd0, MODE_READY, 8'd0),
                       1'b0, '0};
        script[12] = '{STEP_REQ, 8'd0, mk_req(REQ_TICK, 16'h0000, 8'd0, MODE_READY, 8'd0),
                       1'b0, '0};
        script[13] = '{STEP_REQ, 8'd0, mk_req(REQ_DISPATCH, 16'h0000, 8'd0, MODE_READY, 8'd0),
                       1'b0, '0};
        script[14] = '{STEP_REQ, 8'd0,
                       mk_req(REQ_UNUSED, 16'hFFFF, 8'd255, MODE_INVALID, 8'd255),
                       1'b0, '0};
        script[15] = '{STEP_REQ, 8'd0, mk_req(REQ_TICK, 16'h0000, 8'd0, MODE_READY, 8'd0),
                       1'b0, '0};
        script[16] = '{STEP_REQ, 8'd0, mk_req(REQ_DISPATCH, 16'h0000, 8'd0, MODE_READY, 8'd0),
                       1'b0, '0};
        script[17] = '{STEP_REQ, 8'd0,
                       mk_req(REQ_CREATE, 16'hAAAA, 8'd4, MODE_BLOCKED, 8'd0),
                       1'b1, mk_status(STAT_OK, 3'd5)};
        script[18] = '{STEP_REQ, 8'd0,
                       mk_req(REQ_CREATE, 16'h8001, 8'd0, MODE_BLOCKED, 8'd3),
                       1'b1, mk_status(STAT_OK, 3'd6)};
        script[19] = '{STEP_REQ, 8'd0, mk_req(REQ_CREATE, 16'h7FFF, 8'd6, MODE_READY, 8'd1),
                       1'b1, mk_status(STAT_OK, 3'd7)};
        script[20] = '{STEP_REQ, 8'd0, mk_req(REQ_CREATE, 16'h0101, 8'd9, MODE_READY, 8'd0),
                       1'b1, mk_status(STAT_FULL, 3'd0)};
        script[21] = '{STEP_REQ, 8'd0,
                       mk_req(REQ_CREATE, 16'h0000, 8'd255, MODE_READY, 8'd0),
                       1'b1, mk_status(STAT_NULL, 3'd0)};
        script[22] = '{STEP_REQ, 8'd0, mk_req(REQ_TICK, 16'h0000, 8'd0, MODE_READY, 8'd0),
                       1'b0, '0};
        script[23] = '{STEP_REQ, 8'd0, mk_req(REQ_DISPATCH, 16'h0000, 8'd0, MODE_READY, 8'd0),
                       1'b0, '0};
        script[24] = '{STEP_REQ, 8'd0, mk_req(REQ_DISPATCH, 16'h0000, 8'd0, MODE_READY, 8'd0),
                       1'b0, '0};

        phase_limit[0] = 8'($urandom_range(1, 255));
        phase_limit[1] = 8'd1;
        phase_limit[2] = 8'd255;
        phase_limit[3] = 8'($urandom_range(1, 255));
        phase_idle[0]  = 0;
        phase_idle[1]  = 60;
        phase_idle[2]  = 0;
        phase_idle[3]  = 7;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (k = 0; k < N_DIRECTED; k++)
        begin
            if (script[k].kind == STEP_CFG)
            begin
                set_max_period(script[k].cfg_value);
            end
            else
            begin
                issue(script[k].item);
                if (script[k].typed)
                begin
                    pending_results[pending_results.size() - 1] = script[k].want;
                end
            end
        end

        for (ph = 0; ph < N_PHASES; ph++)
        begin
            set_max_period(phase_limit[ph]);
            counted = 0;
            while (counted < PHASE_ITEMS)
            begin
                r = random_request();
                issue(r);
                if (r.req_type != REQ_UNUSED)
                begin
                    counted++;
                end
                pause(phase_idle[ph]);
            end
        end

        start <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/core/ptrt_pkg.sv
rtl/core/periodic_task_release_table_top.sv
rtl/core/ptrt_checker.sv
dv/tb_periodic_task_release_table_top.sv
